FILE: hdl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros used by the checker module of the deframer.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/sdf_pkg.sv
// ---------------------------------------------------------------------------
// sdf_pkg
// Types and constants shared by the state record deframer modules.
// ---------------------------------------------------------------------------
package sdf_pkg;

	// Header geometry.
	localparam int HEADER_BYTES = 48;
	localparam int HDR_POS_W    = 6;
	localparam logic [HDR_POS_W-1:0] HDR_LAST  = HDR_POS_W'(HEADER_BYTES - 1);
	localparam logic [HDR_POS_W-1:0] ID_BYTES  = 6'd6;   // magic and version
	localparam logic [HDR_POS_W-1:0] LEN_FIRST = 6'd24;  // first size byte
	localparam logic [HDR_POS_W-1:0] LEN_END   = 6'd44;  // one past last size byte

	// Field kinds as reported on the result stream.
	localparam logic [3:0] KIND_HEADER  = 4'd0;
	localparam logic [3:0] KIND_OWNER   = 4'd1;
	localparam logic [3:0] KIND_TARGET  = 4'd2;
	localparam logic [3:0] KIND_SCOPE   = 4'd3;
	localparam logic [3:0] KIND_KEYLEN  = 4'd4;
	localparam logic [3:0] KIND_VALLEN  = 4'd5;
	localparam logic [3:0] KIND_KEY     = 4'd6;
	localparam logic [3:0] KIND_VALUE   = 4'd7;
	localparam logic [3:0] KIND_PAYLOAD = 4'd8;
	localparam logic [3:0] KIND_DISCARD = 4'd9;

	// Frame status codes.
	localparam logic [2:0] ST_OK          = 3'd0;
	localparam logic [2:0] ST_BAD_MAGIC   = 3'd1;
	localparam logic [2:0] ST_BAD_VERSION = 3'd2;
	localparam logic [2:0] ST_TRUNCATED   = 3'd3;
	localparam logic [2:0] ST_MISMATCH    = 3'd4;

	// Configuration registers.
	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_MAGIC   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_VERSION = 1'd1;
	localparam logic [31:0] MAGIC_RESET   = 32'h4D4F4431;
	localparam logic [15:0] VERSION_RESET = 16'd1;

	localparam int OUT_TDATA_W = 48;

	typedef struct packed {
		logic [31:0] magic;
		logic [15:0] version;
	} cfg_regs_t;

	typedef struct packed {
		logic [3:0]  kind;
		logic [7:0]  data;
		logic [31:0] idx;
		logic        last;
		logic [2:0]  status;
	} result_t;

endpackage

FILE: hdl/sdf_cfg.sv
// ---------------------------------------------------------------------------
// sdf_cfg
// Configuration registers: expected magic and expected version.
// ---------------------------------------------------------------------------
module sdf_cfg import sdf_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output logic                 cfg_ready,
	output cfg_regs_t            regs
);

	logic [31:0] magic_q;
	logic [15:0] version_q;

	// Writes complete in the cycle they are offered.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q   <= MAGIC_RESET;
			version_q <= VERSION_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				CFG_MAGIC:   magic_q   <= cfg_data;
				CFG_VERSION: version_q <= cfg_data[15:0];
				default: begin
				end
			endcase
		end
	end

	assign regs.magic   = magic_q;
	assign regs.version = version_q;

endmodule

FILE: hdl/sdf_parser.sv
// ---------------------------------------------------------------------------
// sdf_parser
// Per-byte parse state of the deframer and the tag of the current byte.
// ---------------------------------------------------------------------------
module sdf_parser import sdf_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      en,
	input  logic [7:0] in_byte,
	input  logic      is_last,
	input  cfg_regs_t cfg,
	output result_t   res
);

	typedef enum logic [9:0] {
		PH_HEADER  = 10'b0000000001,
		PH_OWNER   = 10'b0000000010,
		PH_TARGET  = 10'b0000000100,
		PH_SCOPE   = 10'b0000001000,
		PH_KEYLEN  = 10'b0000010000,
		PH_VALLEN  = 10'b0000100000,
		PH_KEY     = 10'b0001000000,
		PH_VALUE   = 10'b0010000000,
		PH_PAYLOAD = 10'b0100000000,
		PH_DISCARD = 10'b1000000000
	} phase_t;

	typedef struct packed {
		logic       found;
		logic [1:0] k;
	} str_pick_t;

	// First non-empty string at or after position s.
	function automatic str_pick_t pick_string(input logic [1:0] s, input logic [2:0] nz);
		str_pick_t p;
		p.found = 1'b0;
		p.k     = 2'd0;
		for (int i = 2; i >= 0; i--) begin
			if ((i >= int'(s)) && nz[i]) begin
				p.found = 1'b1;
				p.k     = 2'(i);
			end
		end
		return p;
	endfunction

	// Length words: owner, target, scope, entry count, payload size.
	phase_t                phase_q, phase_d;
	logic [HDR_POS_W-1:0]  hpos_q, hpos_d;
	logic [47:0]           hdr_q, hdr_d;
	logic [31:0]           len_q [5];
	logic [31:0]           len_d [5];
	logic [31:0]           fbl_q, fbl_d;
	logic [31:0]           cnt_q, cnt_d;
	logic [31:0]           pvl_q, pvl_d;
	logic [31:0]           seen_q, seen_d;
	logic [2:0]            err_q, err_d;

	logic                  req_str, req_val, req_ent;
	logic [1:0]            str_start;
	logic [31:0]           ent_cnt;
	logic [31:0]           fbl_dec;
	logic [HDR_POS_W-1:0]  off;
	logic [1:0]            lane;
	str_pick_t             pick;
	logic [2:0]            status;
	logic [3:0]            kind;

	always_comb begin
		phase_d   = phase_q;
		hpos_d    = hpos_q;
		hdr_d     = hdr_q;
		len_d     = len_q;
		fbl_d     = fbl_q;
		cnt_d     = cnt_q;
		pvl_d     = pvl_q;
		seen_d    = seen_q;
		err_d     = err_q;
		req_str   = 1'b0;
		req_val   = 1'b0;
		req_ent   = 1'b0;
		str_start = 2'd0;
		ent_cnt   = cnt_q;
		pick      = '0;
		off       = hpos_q - LEN_FIRST;
		lane      = hpos_q[1:0];
		fbl_dec   = (fbl_q != 32'd0) ? fbl_q - 32'd1 : fbl_q;

		case (phase_q)
			PH_HEADER: begin
				if (hpos_q < ID_BYTES)
					hdr_d[{hpos_q[2:0], 3'b000} +: 8] = in_byte;
				if ((hpos_q >= LEN_FIRST) && (hpos_q < LEN_END))
					len_d[off[4:2]][{off[1:0], 3'b000} +: 8] = in_byte;
				if (hpos_q >= HDR_LAST) begin
					hpos_d = '0;
					if (hdr_q[31:0] != cfg.magic) begin
						err_d   = ST_BAD_MAGIC;
						phase_d = PH_DISCARD;
					end else if (hdr_q[47:32] != cfg.version) begin
						err_d   = ST_BAD_VERSION;
						phase_d = PH_DISCARD;
					end else begin
						req_str   = 1'b1;
						str_start = 2'd0;
					end
				end else begin
					hpos_d = hpos_q + 6'd1;
				end
			end
			PH_OWNER: begin
				fbl_d = fbl_dec;
				if (fbl_dec == 32'd0) begin
					req_str   = 1'b1;
					str_start = 2'd1;
				end
			end
			PH_TARGET: begin
				fbl_d = fbl_dec;
				if (fbl_dec == 32'd0) begin
					req_str   = 1'b1;
					str_start = 2'd2;
				end
			end
			PH_SCOPE: begin
				fbl_d = fbl_dec;
				if (fbl_dec == 32'd0) begin
					req_str   = 1'b1;
					str_start = 2'd3;
				end
			end
			PH_KEYLEN: begin
				// The key length collects in the byte counter register.
				fbl_d[{lane, 3'b000} +: 8] = in_byte;
				if (lane == 2'd3) begin
					hpos_d  = '0;
					pvl_d   = '0;
					phase_d = PH_VALLEN;
				end else begin
					hpos_d = {4'b0000, lane} + 6'd1;
				end
			end
			PH_VALLEN: begin
				pvl_d[{lane, 3'b000} +: 8] = in_byte;
				if (lane == 2'd3) begin
					hpos_d = '0;
					if (fbl_q != 32'd0)
						phase_d = PH_KEY;
					else
						req_val = 1'b1;
				end else begin
					hpos_d = {4'b0000, lane} + 6'd1;
				end
			end
			PH_KEY: begin
				fbl_d = fbl_dec;
				if (fbl_dec == 32'd0)
					req_val = 1'b1;
			end
			PH_VALUE: begin
				fbl_d = fbl_dec;
				if (fbl_dec == 32'd0) begin
					req_ent = 1'b1;
					ent_cnt = cnt_q + 32'd1;
				end
			end
			PH_PAYLOAD: begin
				if (seen_q != 32'hFFFF_FFFF)
					seen_d = seen_q + 32'd1;
			end
			PH_DISCARD: begin
			end
			default: begin
			end
		endcase

		// Start of a value, or next entry when the value is empty.
		if (req_val) begin
			if (pvl_d != 32'd0) begin
				phase_d = PH_VALUE;
				fbl_d   = pvl_d;
			end else begin
				req_ent = 1'b1;
				ent_cnt = cnt_q + 32'd1;
			end
		end

		// Next non-empty string, or the metadata when none is left.
		if (req_str) begin
			pick = pick_string(str_start,
				{len_d[2] != 32'd0, len_d[1] != 32'd0, len_d[0] != 32'd0});
			if (pick.found) begin
				case (pick.k)
					2'd0: begin
						phase_d = PH_OWNER;
						fbl_d   = len_d[0];
					end
					2'd1: begin
						phase_d = PH_TARGET;
						fbl_d   = len_d[1];
					end
					default: begin
						phase_d = PH_SCOPE;
						fbl_d   = len_d[2];
					end
				endcase
			end else begin
				req_ent = 1'b1;
			end
		end

		// Next metadata entry, or the payload once all are done.
		if (req_ent) begin
			cnt_d = ent_cnt;
			if (ent_cnt < len_d[3]) begin
				phase_d = PH_KEYLEN;
				hpos_d  = '0;
				fbl_d   = '0;
			end else begin
				phase_d = PH_PAYLOAD;
			end
		end
	end

	always_comb begin
		if (err_d != ST_OK)
			status = err_d;
		else if (phase_d != PH_PAYLOAD)
			status = ST_TRUNCATED;
		else if (seen_d != len_d[4])
			status = ST_MISMATCH;
		else
			status = ST_OK;
	end

	always_comb begin
		case (phase_q)
			PH_HEADER:  kind = KIND_HEADER;
			PH_OWNER:   kind = KIND_OWNER;
			PH_TARGET:  kind = KIND_TARGET;
			PH_SCOPE:   kind = KIND_SCOPE;
			PH_KEYLEN:  kind = KIND_KEYLEN;
			PH_VALLEN:  kind = KIND_VALLEN;
			PH_KEY:     kind = KIND_KEY;
			PH_VALUE:   kind = KIND_VALUE;
			PH_PAYLOAD: kind = KIND_PAYLOAD;
			default:    kind = KIND_DISCARD;
		endcase
	end

	assign res.kind   = kind;
	assign res.data   = in_byte;
	assign res.idx    = ((phase_q == PH_KEYLEN) || (phase_q == PH_VALLEN) ||
		(phase_q == PH_KEY) || (phase_q == PH_VALUE)) ? cnt_q : 32'd0;
	assign res.last   = is_last;
	assign res.status = is_last ? status : ST_OK;

	// The last byte of a datagram returns the parser to its reset state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_HEADER;
			hpos_q  <= '0;
			hdr_q   <= '0;
			len_q   <= '{default: '0};
			fbl_q   <= '0;
			cnt_q   <= '0;
			pvl_q   <= '0;
			seen_q  <= '0;
			err_q   <= ST_OK;
		end else if (en) begin
			if (is_last) begin
				phase_q <= PH_HEADER;
				hpos_q  <= '0;
				hdr_q   <= '0;
				len_q   <= '{default: '0};
				fbl_q   <= '0;
				cnt_q   <= '0;
				pvl_q   <= '0;
				seen_q  <= '0;
				err_q   <= ST_OK;
			end else begin
				phase_q <= phase_d;
				hpos_q  <= hpos_d;
				hdr_q   <= hdr_d;
				len_q   <= len_d;
				fbl_q   <= fbl_d;
				cnt_q   <= cnt_d;
				pvl_q   <= pvl_d;
				seen_q  <= seen_d;
				err_q   <= err_d;
			end
		end
	end

endmodule

FILE: hdl/sdf_outbuf.sv
// ---------------------------------------------------------------------------
// sdf_outbuf
// Two-entry output buffer: result register plus skid register.
// ---------------------------------------------------------------------------
module sdf_outbuf import sdf_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  result_t din,
	output logic    in_ready,
	output logic    out_valid,
	input  logic    out_ready,
	output result_t dout
);

	result_t main_q, skid_q;
	logic    main_v_q, skid_v_q;
	logic    pop;

	assign pop       = main_v_q && out_ready;
	assign in_ready  = !skid_v_q;
	assign out_valid = main_v_q;
	assign dout      = main_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (pop) begin
			if (skid_v_q)
				skid_v_q <= 1'b0;
			else
				main_v_q <= push;
		end else if (push) begin
			if (main_v_q)
				skid_v_q <= 1'b1;
			else
				main_v_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			if (skid_v_q)
				main_q <= skid_q;
			else if (push)
				main_q <= din;
		end else if (push) begin
			if (main_v_q)
				skid_q <= din;
			else
				main_q <= din;
		end
	end

endmodule

FILE: hdl/state_record_deframer.sv
// ---------------------------------------------------------------------------
// state_record_deframer
// Byte-serial deframer that tags each datagram byte with its record field.
// ---------------------------------------------------------------------------
// Usage:
// Datagram bytes enter on the in_ stream, one byte per word, with in_tlast on
// the final byte. Each accepted word yields exactly one word on the out_
// stream: the byte, its field kind on out_tuser, the metadata entry number,
// and on the word that carries out_tlast the frame status.
// A word is tagged by the parse state in the cycle it is accepted and is
// registered in the result register, or the skid register while it is held.
// Throughput is one word per cycle while out_tready is high; the parse step
// is a single pass of counter and compare logic between the parse registers.
// A two-entry output buffer decouples the sides: while the receiver stalls,
// one more word is still accepted, then in_tready drops until a result is
// taken. The cfg_ channel sets the expected magic and version; it is always
// ready and is meant to be written only while no datagram is in progress.
// Reset returns the parser to the header phase, empties the output buffer
// and loads the register defaults.
// ---------------------------------------------------------------------------
module state_record_deframer import sdf_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	// Input stream.
	input  logic                   in_tvalid,
	output logic                   in_tready,
	input  logic [7:0]             in_tdata,   // [7:0] in_byte
	input  logic                   in_tlast,   // is_last
	// Result stream.
	output logic                   out_tvalid,
	input  logic                   out_tready,
	output logic [OUT_TDATA_W-1:0] out_tdata,  // [7:0] out_byte, [39:8] entry_index,
	                                           // [42:40] status, [47:43] zero
	output logic [3:0]             out_tuser,  // [3:0] field_kind
	output logic                   out_tlast,  // frame_end
	// Configuration write channel.
	input  logic                   cfg_valid,
	output logic                   cfg_ready,
	input  logic [CFG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]            cfg_data
);

	cfg_regs_t regs;
	result_t   res;
	result_t   res_out;
	logic      accept;

	// A byte is accepted whenever the output buffer has room for its result.
	assign accept = in_tvalid && in_tready;

	sdf_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg_ready (cfg_ready),
		.regs      (regs)
	);

	// The parser advances only on an accepted byte.
	sdf_parser u_parser (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (accept),
		.in_byte (in_tdata),
		.is_last (in_tlast),
		.cfg     (regs),
		.res     (res)
	);

	sdf_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.din       (res),
		.in_ready  (in_tready),
		.out_valid (out_tvalid),
		.out_ready (out_tready),
		.dout      (res_out)
	);

	// Pack the result word, lowest field first.
	assign out_tdata = {5'b00000, res_out.status, res_out.idx, res_out.data};
	assign out_tuser = res_out.kind;
	assign out_tlast = res_out.last;

endmodule

FILE: hdl/sdf_checker.sv
// ---------------------------------------------------------------------------
// sdf_checker
// Port-level checks of the deframer, bound to the top level.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module sdf_checker import sdf_pkg::*; (
	input logic                   clk,
	input logic                   arst_n,
	input logic                   in_tvalid,
	input logic                   in_tready,
	input logic                   out_tvalid,
	input logic                   out_tready,
	input logic [OUT_TDATA_W-1:0] out_tdata,
	input logic [3:0]             out_tuser,
	input logic                   out_tlast
);

	logic in_flight;
	logic meta_kind;

	assign in_flight = in_tvalid;
	assign meta_kind = (out_tuser == KIND_KEYLEN) || (out_tuser == KIND_VALLEN) ||
		(out_tuser == KIND_KEY) || (out_tuser == KIND_VALUE);

	// Input back-pressure only comes from results that wait on the output.
	`ASSERT_IMPLY(a_stall_has_result, clk, arst_n, !in_tready, out_tvalid, "input stalled with no pending result")

	// A stalled result word holds its contents.
	`ASSERT_NEXT(a_out_hold, clk, arst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "stalled result changed")

	// Status is only reported on the last word of a datagram.
	`ASSERT_IMPLY(a_status_at_end, clk, arst_n, out_tvalid && !out_tlast, out_tdata[42:40] == ST_OK, "status set before frame end")

	// Entry numbers only accompany metadata bytes.
	`ASSERT_IMPLY(a_index_meta, clk, arst_n, out_tvalid && !meta_kind && (in_flight || !in_flight), out_tdata[39:8] == 32'd0, "entry index on non-metadata byte")

endmodule

bind state_record_deframer sdf_checker u_sdf_checker (.*);
